@@ rtl/clre_pkg.sv @@
// shared types, constants and encoding helpers for the character lcd row refresh encoder
package clre_pkg;

   localparam int TEXT_ROWS   = 4;
   localparam int TEXT_COLS   = 40;
   localparam int STORE_DEPTH = TEXT_ROWS * TEXT_COLS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int ROW_W       = $clog2(TEXT_ROWS);

   localparam logic [5:0]  COLS_MIN        = 6'd16;
   localparam logic [5:0]  COLS_MAX        = 6'd40;
   localparam logic [2:0]  ROWS_MIN        = 3'd2;
   localparam logic [2:0]  ROWS_MAX        = 3'd4;
   localparam logic [15:0] ORDER_TWO_ROWS  = 16'h7710;
   localparam logic [15:0] ORDER_FOUR_ROWS = 16'h2103;
   localparam logic [7:0]  ADDR_CMD        = 8'h80;
   localparam logic [7:0]  SPACE_CHAR      = 8'h20;
   localparam logic [7:0]  BIT_BL          = 8'h08;
   localparam logic [7:0]  BIT_EN          = 8'h04;
   localparam logic [7:0]  BIT_RS          = 8'h01;

   localparam logic [1:0] REQ_WRITE   = 2'd0;
   localparam logic [1:0] REQ_REFRESH = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;

   localparam logic [2:0] CSR_USED_COLUMNS  = 3'd0;
   localparam logic [2:0] CSR_USED_ROWS     = 3'd1;
   localparam logic [2:0] CSR_BACKLIGHT     = 3'd2;
   localparam logic [2:0] CSR_ORDER_ENABLE  = 3'd3;
   localparam logic [2:0] CSR_CUSTOM_ORDER  = 3'd4;

   typedef struct packed {
      logic [1:0] req_type;
      logic [1:0] cell_row;
      logic [5:0] cell_col;
      logic [7:0] cell_char;
   } req_word_type;

   typedef struct packed {
      logic [47:0] bus_bytes;
      logic        is_data;
      logic        frame_start;
      logic        last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_CLEAR   = 2'd1,
      CMD_REFRESH = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        char_code;
      logic [1:0]        phys;
      logic [ROW_W-1:0]  trow;
      logic              blank;
      logic              frame;
      logic [5:0]        cols;
   } cmd_type;

   typedef struct packed {
      logic [5:0]  used_columns;
      logic [2:0]  used_rows;
      logic        backlight_on;
      logic        custom_order_enable;
      logic [15:0] custom_order;
   } cfg_type;

   function automatic logic [ADDR_W-1:0] store_addr(input logic [ROW_W-1:0] row,
                                                   input logic [5:0] col);
      store_addr = ADDR_W'(row) * ADDR_W'(TEXT_COLS) + ADDR_W'(col);
   endfunction

   function automatic logic [7:0] line_base(input logic [1:0] phys);
      unique case (phys)
         2'd0: line_base = 8'h00;
         2'd1: line_base = 8'h40;
         2'd2: line_base = 8'h14;
         default: line_base = 8'h54;
      endcase
   endfunction

   function automatic logic [47:0] encode(input logic [7:0] val, input logic [7:0] sig,
                                          input logic bl);
      logic [7:0] blb;
      logic [7:0] hi;
      logic [7:0] lo;
      blb = bl ? BIT_BL : 8'h00;
      hi = (val & 8'hf0) | sig | blb;
      lo = {val[3:0], 4'h0} | sig | blb;
      encode = {lo, lo | BIT_EN, lo, hi, hi | BIT_EN, hi};
   endfunction

endpackage

@@ rtl/clre_front.sv @@
// request front end: decodes requests, tracks the row pointer, builds queue commands
module clre_front import clre_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_accept,
   input  req_word_type req_word,
   input  cfg_type      cfg,
   output logic         push,
   output cmd_type      push_cmd
);

   logic [2:0]  next_row_ff, next_row_in;
   logic [5:0]  cols;
   logic [2:0]  rows;
   logic [2:0]  cur_row;
   logic        frame;
   logic [15:0] order;
   logic [2:0]  trow;
   logic        wr_ok;

   always_comb begin
      cols = cfg.used_columns;
      if (cols < COLS_MIN) cols = COLS_MIN;
      if (cols > COLS_MAX) cols = COLS_MAX;
      rows = cfg.used_rows;
      if (rows < ROWS_MIN) rows = ROWS_MIN;
      if (rows > ROWS_MAX) rows = ROWS_MAX;

      frame = (next_row_ff >= rows);
      cur_row = frame ? 3'd0 : next_row_ff;
      order = (rows == ROWS_MIN) ? ORDER_TWO_ROWS : ORDER_FOUR_ROWS;
      if (cfg.custom_order_enable) order = cfg.custom_order;
      trow = 3'(order >> {cur_row[1:0], 2'b00});

      wr_ok = (req_word.cell_col < cols) && (32'(req_word.cell_col) < TEXT_COLS)
              && (32'(req_word.cell_row) < TEXT_ROWS);

      push_cmd.kind      = CMD_WRITE;
      push_cmd.addr      = store_addr(ROW_W'(req_word.cell_row), req_word.cell_col);
      push_cmd.char_code = req_word.cell_char;
      push_cmd.phys      = cur_row[1:0];
      push_cmd.trow      = trow[ROW_W-1:0];
      push_cmd.blank     = !cfg.backlight_on || (32'(trow) >= TEXT_ROWS);
      push_cmd.frame     = frame;
      push_cmd.cols      = cols;

      push = 1'b0;
      next_row_in = next_row_ff;
      unique case (req_word.req_type)
         REQ_WRITE: begin
            push = req_valid && req_accept && wr_ok;
         end
         REQ_CLEAR: begin
            push_cmd.kind = CMD_CLEAR;
            push = req_valid && req_accept;
         end
         REQ_REFRESH: begin
            push_cmd.kind = CMD_REFRESH;
            push = req_valid && req_accept;
            if (push) next_row_in = cur_row + 3'd1;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_row_ff <= 3'd0;
      end else begin
         next_row_ff <= next_row_in;
      end
   end

endmodule

@@ rtl/clre_queue.sv @@
// two-entry command queue between front end and back end
module clre_queue import clre_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/clre_back.sv @@
// back end: character store, row sequencer, read stage and output word register
module clre_back import clre_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         backlight_on,
   input  logic         head_valid,
   input  cmd_type      head_cmd,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_RUN  = 2'b10
   } bk_state_type;

   logic [7:0]             mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] valid_ff, valid_in;

   bk_state_type     state_ff, state_in;
   logic [5:0]       step_ff, step_in;
   logic [5:0]       cols_ff;
   logic [ROW_W-1:0] trow_ff;
   logic             blank_ff;
   logic             frame_ff;
   logic [1:0]       phys_ff;

   logic             s1_vld_ff, s1_vld_in;
   logic             s1_data_ff;
   logic             s1_space_ff;
   logic             s1_frame_ff;
   logic             s1_last_ff;
   logic [1:0]       s1_phys_ff;
   logic [7:0]       rd_ff;

   logic             out_vld_ff, out_vld_in;
   rsp_word_type     out_ff;

   logic              s1_adv;
   logic              issue;
   logic              start;
   logic              mem_wr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        ch;
   logic [7:0]        val;

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

   always_comb begin
      s1_adv  = s1_vld_ff && (!out_vld_ff || !rsp_stall);
      issue   = (state_ff == BK_RUN) && (!s1_vld_ff || s1_adv);
      rd_addr = store_addr(trow_ff, step_ff - 6'd1);
      pop     = 1'b0;
      start   = 1'b0;
      mem_wr  = 1'b0;
      valid_in = valid_ff;
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               case (head_cmd.kind)
                  CMD_WRITE: begin
                     mem_wr = 1'b1;
                     valid_in[head_cmd.addr] = 1'b1;
                  end
                  CMD_CLEAR: begin
                     valid_in = '0;
                  end
                  default: begin
                     start = 1'b1;
                     step_in = 6'd0;
                     state_in = BK_RUN;
                  end
               endcase
            end
         end
         BK_RUN: begin
            if (issue) begin
               step_in = step_ff + 6'd1;
               if (step_ff == cols_ff) state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      s1_vld_in = issue || (s1_vld_ff && !s1_adv);
      out_vld_in = s1_adv || (out_vld_ff && rsp_stall);

      ch  = s1_space_ff ? SPACE_CHAR : rd_ff;
      val = s1_data_ff ? ch : (ADDR_CMD | line_base(s1_phys_ff));
   end

   always_ff @(posedge clock) begin
      if (mem_wr) mem[head_cmd.addr] <= head_cmd.char_code;
      if (issue && step_ff != 6'd0) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cols_ff  <= head_cmd.cols;
         trow_ff  <= head_cmd.trow;
         blank_ff <= head_cmd.blank;
         frame_ff <= head_cmd.frame;
         phys_ff  <= head_cmd.phys;
      end
      if (issue) begin
         s1_data_ff  <= (step_ff != 6'd0);
         s1_space_ff <= blank_ff || !valid_ff[rd_addr];
         s1_frame_ff <= (step_ff == 6'd0) && frame_ff;
         s1_last_ff  <= (step_ff == cols_ff);
         s1_phys_ff  <= phys_ff;
      end
      if (s1_adv) begin
         out_ff.bus_bytes   <= encode(val, s1_data_ff ? BIT_RS : 8'h00, backlight_on);
         out_ff.is_data     <= s1_data_ff;
         out_ff.frame_start <= s1_frame_ff;
         out_ff.last        <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         step_ff    <= 6'd0;
         valid_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         valid_ff   <= valid_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

endmodule

@@ rtl/char_lcd_row_refresh_encoder_top.sv @@
// top level: configuration registers and the front, queue and back end of the row encoder
// A refresh word produces one set-address word and then one character word per used column
// (17 to 41 words); with no stall on the result side it streams one word per cycle. Cell
// writes and clears are handled by the back end while it is idle and pass through a two-deep
// queue, so up to two requests are taken while a row is still going out. The store needs no
// clearing pass: per-cell valid bits read unwritten cells as spaces.
module char_lcd_row_refresh_encoder_top import clre_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   assign req_stall = q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_USED_COLUMNS: cfg_in.used_columns        = csr_wr_data[5:0];
            CSR_USED_ROWS:    cfg_in.used_rows           = csr_wr_data[2:0];
            CSR_BACKLIGHT:    cfg_in.backlight_on        = csr_wr_data[0];
            CSR_ORDER_ENABLE: cfg_in.custom_order_enable = csr_wr_data[0];
            CSR_CUSTOM_ORDER: cfg_in.custom_order        = csr_wr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.used_columns        <= COLS_MIN;
         cfg_ff.used_rows           <= ROWS_MIN;
         cfg_ff.backlight_on        <= 1'b1;
         cfg_ff.custom_order_enable <= 1'b0;
         cfg_ff.custom_order        <= 16'h0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clre_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_accept (!q_full),
      .req_word   (req_word),
      .cfg        (cfg_ff),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   clre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   clre_back u_back (
      .clock        (clock),
      .reset        (reset),
      .backlight_on (cfg_ff.backlight_on),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word)
   );

endmodule
